// ===== design/gcode_modal_state_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// G-code modal state tracker assertion macros
// Shorthand for the concurrent checks used by the tracker checker.
// ----------------------------------------------------------------------------
`ifndef GCODE_MODAL_STATE_TRACKER_MACROS_SVH
`define GCODE_MODAL_STATE_TRACKER_MACROS_SVH

// check with the property disabled while reset is high
`define GMST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gmst assertion failed");

// check that is also evaluated while reset is high
`define GMST_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("gmst assertion failed");

`endif

// ===== design/gmst_pkg.sv =====
// ----------------------------------------------------------------------------
// G-code modal state tracker package
// Item types, command codes, G numbers and the flag reset pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gmst_pkg;

   localparam logic [1:0] CMD_SET       = 2'd0;
   localparam logic [1:0] CMD_CLEAR_ONE = 2'd1;
   localparam logic [1:0] CMD_CLEAR_ALL = 2'd2;
   localparam logic [1:0] CMD_NEW_BLOCK = 2'd3;

   localparam logic [7:0] G00  = 8'd0;
   localparam logic [7:0] G01  = 8'd1;
   localparam logic [7:0] G02  = 8'd2;
   localparam logic [7:0] G03  = 8'd3;
   localparam logic [7:0] G09  = 8'd9;
   localparam logic [7:0] G10  = 8'd10;
   localparam logic [7:0] G17  = 8'd17;
   localparam logic [7:0] G18  = 8'd18;
   localparam logic [7:0] G19  = 8'd19;
   localparam logic [7:0] G20  = 8'd20;
   localparam logic [7:0] G21  = 8'd21;
   localparam logic [7:0] G22  = 8'd22;
   localparam logic [7:0] G28  = 8'd28;
   localparam logic [7:0] G40  = 8'd40;
   localparam logic [7:0] G41  = 8'd41;
   localparam logic [7:0] G42  = 8'd42;
   localparam logic [7:0] G43  = 8'd43;
   localparam logic [7:0] G44  = 8'd44;
   localparam logic [7:0] G49  = 8'd49;
   localparam logic [7:0] G51  = 8'd51;
   localparam logic [7:0] G53  = 8'd53;
   localparam logic [7:0] G54  = 8'd54;
   localparam logic [7:0] G55  = 8'd55;
   localparam logic [7:0] G56  = 8'd56;
   localparam logic [7:0] G57  = 8'd57;
   localparam logic [7:0] G58  = 8'd58;
   localparam logic [7:0] G59  = 8'd59;
   localparam logic [7:0] G61  = 8'd61;
   localparam logic [7:0] G64  = 8'd64;
   localparam logic [7:0] G80  = 8'd80;
   localparam logic [7:0] G81  = 8'd81;
   localparam logic [7:0] G83  = 8'd83;
   localparam logic [7:0] G90  = 8'd90;
   localparam logic [7:0] G91  = 8'd91;
   localparam logic [7:0] G93  = 8'd93;
   localparam logic [7:0] G94  = 8'd94;
   localparam logic [7:0] G98  = 8'd98;
   localparam logic [7:0] G99  = 8'd99;
   localparam logic [7:0] G102 = 8'd102;
   localparam logic [7:0] G103 = 8'd103;

   localparam logic [6:0] FRACTION_ONE = 7'd1;
   localparam logic [2:0] OFFSET_RESET = 3'd1;

   // G1, G9, G17, G54, G61, G80, G90, G94, G98
   localparam logic [127:0] FLAG_RESET = (128'd1 << 1)  | (128'd1 << 9)  |
                                         (128'd1 << 17) | (128'd1 << 54) |
                                         (128'd1 << 61) | (128'd1 << 80) |
                                         (128'd1 << 90) | (128'd1 << 94) |
                                         (128'd1 << 98);

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] code_number;
      logic       has_fraction;
      logic [6:0] fraction_value;
   } req_type;

   typedef struct packed {
      logic        code_known;
      logic [7:0]  reported_code;
      logic [63:0] active_low;
      logic [63:0] active_high;
      logic [2:0]  work_offset;
      logic        exact_stop;
      logic        abs_arc_centres;
      logic        drill_plane_init;
   } rsp_type;

   typedef struct packed {
      logic [2:0] offset_index;
      logic       stop_mode;
      logic       abs_centres;
      logic       drill_init_mark;
   } mode_type;

   function automatic logic [6:0] flag_pos(input logic [7:0] code);
      return code[6:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/gmst_channels.sv =====
// ----------------------------------------------------------------------------
// G-code modal state tracker channels
// Valid/ready interfaces for the command input and the state result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gmst_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] code_number;
   logic       has_fraction;
   logic [6:0] fraction_value;

   modport source (output valid, cmd, code_number, has_fraction, fraction_value,
                   input ready);
   modport sink   (input valid, cmd, code_number, has_fraction, fraction_value,
                   output ready);
endinterface

interface gmst_rsp_if;
   logic        valid;
   logic        ready;
   logic        code_known;
   logic [7:0]  reported_code;
   logic [63:0] active_low;
   logic [63:0] active_high;
   logic [2:0]  work_offset;
   logic        exact_stop;
   logic        abs_arc_centres;
   logic        drill_plane_init;

   modport source (output valid, code_known, reported_code, active_low, active_high,
                          work_offset, exact_stop, abs_arc_centres, drill_plane_init,
                   input ready);
   modport sink   (input valid, code_known, reported_code, active_low, active_high,
                         work_offset, exact_stop, abs_arc_centres, drill_plane_init,
                   output ready);
endinterface

`default_nettype wire

// ===== design/gmst_in_reg.sv =====
// ----------------------------------------------------------------------------
// G-code modal state tracker input register
// Captures one command transfer and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmst_in_reg
   import gmst_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   gmst_req_if.sink     req_if,
   input  wire logic    advance,
   output logic         item_valid,
   output req_type      item
);

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    take;

   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;
   assign valid_in     = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.cmd            <= req_if.cmd;
         item_ff.code_number    <= req_if.code_number;
         item_ff.has_fraction   <= req_if.has_fraction;
         item_ff.fraction_value <= req_if.fraction_value;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== design/gmst_update.sv =====
// ----------------------------------------------------------------------------
// G-code modal state tracker update logic
// Applies one command to the modal state and forms the result snapshot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmst_update
   import gmst_pkg::*;
#(
   parameter int FLAG_COUNT = 128
) (
   input  wire req_type                 item,
   input  wire logic [FLAG_COUNT-1:0]   flags_cur,
   input  wire mode_type                mode_cur,
   output logic [FLAG_COUNT-1:0]        flags_nxt,
   output mode_type                     mode_nxt,
   output rsp_type                      result
);

   logic [127:0] f;
   logic [127:0] f_out;
   mode_type     m;
   logic         known;
   logic [7:0]   rep;
   logic [7:0]   c;

   assign c = item.code_number;

   always_comb begin
      f                 = '0;
      f[FLAG_COUNT-1:0] = flags_cur;
      m                 = mode_cur;
      known             = 1'b0;
      rep               = '0;
      unique case (item.cmd)
         CMD_SET: begin
            known = 1'b1;
            rep   = c;
            unique case (c)
               G28: begin
                  f[flag_pos(G28)] = 1'b1;
               end
               G00, G01: begin
                  f[flag_pos(G00)] = (c == G00);
                  f[flag_pos(G01)] = (c == G01);
                  f[flag_pos(G02)] = 1'b0;
                  f[flag_pos(G03)] = 1'b0;
                  f[flag_pos(G80)] = 1'b1;
                  f[flag_pos(G81)] = 1'b0;
                  f[flag_pos(G83)] = 1'b0;
                  rep              = G80;
               end
               G02, G03: begin
                  f[flag_pos(G00)] = 1'b0;
                  f[flag_pos(G01)] = 1'b0;
                  f[flag_pos(G02)] = (c == G02);
                  f[flag_pos(G03)] = (c == G03);
               end
               G102, G103: begin
                  f[flag_pos(G02)] = 1'b0;
                  f[flag_pos(G03)] = 1'b0;
               end
               G09, G10: begin
                  f[flag_pos(G09)] = (c == G09);
                  f[flag_pos(G10)] = (c == G10);
               end
               G17, G18, G19, G20: begin
                  f[flag_pos(G17)] = (c == G17) || (c == G20);
                  f[flag_pos(G18)] = (c == G18);
                  f[flag_pos(G19)] = (c == G19);
                  f[flag_pos(G20)] = (c == G20);
               end
               G21, G22: begin
                  f[flag_pos(G21)] = (c == G21);
                  f[flag_pos(G22)] = (c == G22);
               end
               G40, G41, G42: begin
                  f[flag_pos(G41)] = (c == G41);
                  f[flag_pos(G42)] = (c == G42);
               end
               G43, G44, G49: begin
                  f[flag_pos(G43)] = (c == G43);
                  f[flag_pos(G44)] = (c == G44);
               end
               G51: begin
                  f[flag_pos(G51)] = 1'b1;
               end
               G53: begin
                  f[flag_pos(G53)] = 1'b1;
               end
               G54, G55, G56, G57, G58, G59: begin
                  f[flag_pos(G28)] = 1'b0;
                  f[flag_pos(G53)] = 1'b0;
                  f[flag_pos(G54)] = (c == G54);
                  f[flag_pos(G55)] = (c == G55);
                  f[flag_pos(G56)] = (c == G56);
                  f[flag_pos(G57)] = (c == G57);
                  f[flag_pos(G58)] = (c == G58);
                  f[flag_pos(G59)] = (c == G59);
                  m.offset_index   = 3'(c - G53);
               end
               G61: begin
                  f[flag_pos(G61)] = 1'b1;
                  f[flag_pos(G64)] = 1'b0;
                  m.stop_mode      = item.has_fraction &&
                                     (item.fraction_value == FRACTION_ONE);
               end
               G64: begin
                  f[flag_pos(G61)] = 1'b0;
                  f[flag_pos(G64)] = 1'b1;
                  m.stop_mode      = 1'b0;
               end
               G80: begin
                  f[flag_pos(G80)] = 1'b1;
                  f[flag_pos(G81)] = 1'b0;
                  f[flag_pos(G83)] = 1'b0;
               end
               G81, G83: begin
                  // fresh drill cycle only when none was already active
                  if (!f[flag_pos(G81)] && !f[flag_pos(G83)]) begin
                     m.drill_init_mark = 1'b1;
                  end
                  f[flag_pos(G81)] = (c == G81);
                  f[flag_pos(G83)] = (c == G83);
                  f[flag_pos(G80)] = 1'b0;
               end
               G90, G91: begin
                  if (!item.has_fraction) begin
                     f[flag_pos(G90)] = (c == G90);
                     f[flag_pos(G91)] = (c == G91);
                  end else if (item.fraction_value == FRACTION_ONE) begin
                     m.abs_centres = (c == G90);
                  end
               end
               G93, G94: begin
                  f[flag_pos(G93)] = (c == G93);
                  f[flag_pos(G94)] = (c == G94);
               end
               G98, G99: begin
                  f[flag_pos(G98)] = (c == G98);
                  f[flag_pos(G99)] = (c == G99);
               end
               default: begin
                  known = 1'b0;
                  rep   = '0;
               end
            endcase
         end
         CMD_CLEAR_ONE: begin
            if (!c[7]) begin
               f[c[6:0]] = 1'b0;
            end
         end
         CMD_CLEAR_ALL: begin
            f                = '0;
            f[flag_pos(G80)] = 1'b1;
         end
         CMD_NEW_BLOCK: begin
            m.drill_init_mark = 1'b0;
         end
         default: begin
            m = mode_cur;
         end
      endcase
   end

   // flags at or beyond the count are never stored
   always_comb begin
      f_out = '0;
      f_out[FLAG_COUNT-1:0] = f[FLAG_COUNT-1:0];
   end

   assign flags_nxt               = f[FLAG_COUNT-1:0];
   assign mode_nxt                = m;
   assign result.code_known       = known;
   assign result.reported_code    = rep;
   assign result.active_low       = f_out[63:0];
   assign result.active_high      = f_out[127:64];
   assign result.work_offset      = m.offset_index;
   assign result.exact_stop       = m.stop_mode;
   assign result.abs_arc_centres  = m.abs_centres;
   assign result.drill_plane_init = m.drill_init_mark;

endmodule

`default_nettype wire

// ===== design/gmst_out_reg.sv =====
// ----------------------------------------------------------------------------
// G-code modal state tracker result register
// Holds one result until the receiver takes the transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmst_out_reg
   import gmst_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type result,
   output logic         can_load,
   gmst_rsp_if.source   rsp_if
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type result_ff;

   assign can_load = !valid_ff || rsp_if.ready;
   assign valid_in = load || (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_if.valid            = valid_ff;
   assign rsp_if.code_known       = result_ff.code_known;
   assign rsp_if.reported_code    = result_ff.reported_code;
   assign rsp_if.active_low       = result_ff.active_low;
   assign rsp_if.active_high      = result_ff.active_high;
   assign rsp_if.work_offset      = result_ff.work_offset;
   assign rsp_if.exact_stop       = result_ff.exact_stop;
   assign rsp_if.abs_arc_centres  = result_ff.abs_arc_centres;
   assign rsp_if.drill_plane_init = result_ff.drill_plane_init;

endmodule

`default_nettype wire

// ===== design/gcode_modal_state_tracker.sv =====
// ----------------------------------------------------------------------------
// G-code modal state tracker
// Keeps the modal G-code state and returns a snapshot after every command.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one command per transfer: set a G code, clear one flag,
//   clear all flags (G80 then set), or start a new block. rsp_if returns one
//   result per command: whether a set named a handled code, the reported
//   code, the 128 G flags and the offset, exact-stop, arc-centre and
//   drill-plane modes after the command.
//   From the req_if transfer to the earliest rsp_if transfer, a command
//   passes one input register, then the modal update into the result
//   register.
//   Throughput is one command per cycle unless rsp_if stalls; the modal
//   update is a single decode feeding the state and result registers.
//   Reset loads G1, G9, G17, G54, G61, G80, G90, G94 and G98, work offset 1,
//   all modes off, and empties both registers.
//   When rsp_if stalls, the result holds, the input register still takes one
//   more command, and req_if.ready then drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcode_modal_state_tracker
   import gmst_pkg::*;
#(
   parameter int FLAG_COUNT = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   gmst_req_if.sink     req_if,
   gmst_rsp_if.source   rsp_if
);

   logic                  item_valid;
   req_type               item;
   logic                  can_load;
   logic                  advance;
   logic [FLAG_COUNT-1:0] flags_ff;
   logic [FLAG_COUNT-1:0] flags_in;
   mode_type              mode_ff;
   mode_type              mode_in;
   rsp_type               result;

   assign advance = item_valid && can_load;

   gmst_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   gmst_update #(
      .FLAG_COUNT (FLAG_COUNT)
   ) u_update (
      .item      (item),
      .flags_cur (flags_ff),
      .mode_cur  (mode_ff),
      .flags_nxt (flags_in),
      .mode_nxt  (mode_in),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff                <= FLAG_RESET[FLAG_COUNT-1:0];
         mode_ff.offset_index    <= OFFSET_RESET;
         mode_ff.stop_mode       <= 1'b0;
         mode_ff.abs_centres     <= 1'b0;
         mode_ff.drill_init_mark <= 1'b0;
      end else if (advance) begin
         flags_ff <= flags_in;
         mode_ff  <= mode_in;
      end
   end

   gmst_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .can_load (can_load),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire

// ===== design/gmst_checker.sv =====
// ----------------------------------------------------------------------------
// G-code modal state tracker checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gcode_modal_state_tracker_macros.svh"

module gmst_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        code_known,
   input wire logic [7:0]  reported_code,
   input wire logic [63:0] active_low,
   input wire logic [63:0] active_high,
   input wire logic [2:0]  work_offset,
   input wire logic        exact_stop,
   input wire logic        abs_arc_centres,
   input wire logic        drill_plane_init
);

   logic [142:0] payload;

   assign payload = {code_known, reported_code, active_low, active_high, work_offset,
                     exact_stop, abs_arc_centres, drill_plane_init};

   `GMST_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> !rsp_valid)

   `GMST_ASSERT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload))

   `GMST_ASSERT(a_offset_range, clock, reset, rsp_valid |-> work_offset >= 3'd1 && work_offset <= 3'd6)

   `GMST_ASSERT(a_unknown_reports_zero, clock, reset, rsp_valid && !code_known |-> reported_code == 8'd0)

   `GMST_ASSERT(a_upper_flags_clear, clock, reset, rsp_valid |-> active_high[63:40] == 24'd0)

endmodule

bind gcode_modal_state_tracker gmst_checker u_gmst_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .code_known       (rsp_if.code_known),
   .reported_code    (rsp_if.reported_code),
   .active_low       (rsp_if.active_low),
   .active_high      (rsp_if.active_high),
   .work_offset      (rsp_if.work_offset),
   .exact_stop       (rsp_if.exact_stop),
   .abs_arc_centres  (rsp_if.abs_arc_centres),
   .drill_plane_init (rsp_if.drill_plane_init)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// G-code modal state tracker testbench
// Drives set, clear-one, clear-all and new-block commands through the request
// channel and checks every result against a local model of the modal state,
// under phases of sender idling, receiver stalls and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import gmst_pkg::*;

   localparam int FLAG_LIMIT     = 128;
   localparam int HOLD_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int END_CYCLES     = 10;
   localparam int PHASE_ITEMS    = 110;

   logic clock = 1'b0;
   logic reset;

   gmst_req_if req_if ();
   gmst_rsp_if rsp_if ();

   gcode_modal_state_tracker dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #1 clock = ~clock;

   req_type pending_cmds [$];
   rsp_type expected_state [$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_req_count = 0;
   int      hold_ack_count = 0;
   int      hold_left = 0;
   int      idle_cycles = 0;

   logic [7:0] known_codes [$] = '{G00, G01, G02, G03, G09, G10, G17, G18, G19, G20,
                                   G21, G22, G28, G40, G41, G42, G43, G44, G49, G51,
                                   G53, G54, G55, G56, G57, G58, G59, G61, G64, G80,
                                   G81, G83, G90, G91, G93, G94, G98, G99, G102, G103};

   // modal state model
   logic [127:0] model_flags;
   logic [2:0]   model_offset;
   logic         model_stop;
   logic         model_abs;
   logic         model_drill;

   function automatic void put_flag(input logic [7:0] n, input logic v);
      if (int'(n) < FLAG_LIMIT) model_flags[n[6:0]] = v;
   endfunction

   function automatic void cancel_drill();
      put_flag(G80, 1'b1);
      put_flag(G81, 1'b0);
      put_flag(G83, 1'b0);
   endfunction

   function automatic logic apply_g(input logic [7:0] code, input logic frac,
                                    input logic [6:0] fval, output logic [7:0] rep);
      rep = code;
      case (code)
         G28: put_flag(G28, 1'b1);
         G00, G01: begin
            put_flag(G00, code == G00);
            put_flag(G01, code == G01);
            put_flag(G02, 1'b0);
            put_flag(G03, 1'b0);
            cancel_drill();
            rep = G80;
         end
         G02, G03: begin
            put_flag(G00, 1'b0);
            put_flag(G01, 1'b0);
            put_flag(G02, code == G02);
            put_flag(G03, code == G03);
         end
         G102, G103: begin
            put_flag(G02, 1'b0);
            put_flag(G03, 1'b0);
         end
         G09, G10: begin
            put_flag(G09, code == G09);
            put_flag(G10, code == G10);
         end
         G17, G18, G19, G20: begin
            put_flag(G17, code == G17 || code == G20);
            put_flag(G18, code == G18);
            put_flag(G19, code == G19);
            put_flag(G20, code == G20);
         end
         G21, G22: begin
            put_flag(G21, code == G21);
            put_flag(G22, code == G22);
         end
         G40, G41, G42: begin
            put_flag(G41, code == G41);
            put_flag(G42, code == G42);
         end
         G43, G44, G49: begin
            put_flag(G43, code == G43);
            put_flag(G44, code == G44);
         end
         G51: put_flag(G51, 1'b1);
         G53: put_flag(G53, 1'b1);
         G54, G55, G56, G57, G58, G59: begin
            put_flag(G28, 1'b0);
            put_flag(G53, 1'b0);
            for (logic [7:0] g = G54; g <= G59; g++) put_flag(g, g == code);
            model_offset = 3'(code - G53);
         end
         G61: begin
            put_flag(G61, 1'b1);
            put_flag(G64, 1'b0);
            model_stop = frac && fval == FRACTION_ONE;
         end
         G64: begin
            put_flag(G61, 1'b0);
            put_flag(G64, 1'b1);
            model_stop = 1'b0;
         end
         G80: cancel_drill();
         G81, G83: begin
            if (!model_flags[flag_pos(G83)] && !model_flags[flag_pos(G81)])
               model_drill = 1'b1;
            put_flag(G81, code == G81);
            put_flag(G83, code == G83);
            put_flag(G80, 1'b0);
         end
         G90, G91: begin
            if (!frac) begin
               put_flag(G90, code == G90);
               put_flag(G91, code == G91);
            end else if (fval == FRACTION_ONE) begin
               model_abs = code == G90;
            end
         end
         G93, G94: begin
            put_flag(G93, code == G93);
            put_flag(G94, code == G94);
         end
         G98, G99: begin
            put_flag(G98, code == G98);
            put_flag(G99, code == G99);
         end
         default: begin
            rep = 8'd0;
            return 1'b0;
         end
      endcase
      return 1'b1;
   endfunction

   function automatic rsp_type predict_state(input req_type r);
      rsp_type    e;
      logic [7:0] rep;
      logic       known;
      known = 1'b0;
      rep   = 8'd0;
      case (r.cmd)
         CMD_SET:       known = apply_g(r.code_number, r.has_fraction, r.fraction_value, rep);
         CMD_CLEAR_ONE: put_flag(r.code_number, 1'b0);
         CMD_CLEAR_ALL: begin
            model_flags = '0;
            cancel_drill();
         end
         default:       model_drill = 1'b0;
      endcase
      e.code_known       = known;
      e.reported_code    = known ? rep : 8'd0;
      e.active_low       = model_flags[63:0];
      e.active_high      = model_flags[127:64];
      e.work_offset      = model_offset;
      e.exact_stop       = model_stop;
      e.abs_arc_centres  = model_abs;
      e.drill_plane_init = model_drill;
      return e;
   endfunction

   function automatic req_type make_cmd(input logic [1:0] cmd, input logic [7:0] code,
                                        input logic frac, input logic [6:0] fval);
      req_type r;
      r.cmd            = cmd;
      r.code_number    = code;
      r.has_fraction   = frac;
      r.fraction_value = fval;
      return r;
   endfunction

   function automatic req_type random_cmd();
      req_type r;
      int      pick;
      pick             = $urandom_range(99);
      r.has_fraction   = $urandom_range(3) == 0;
      r.fraction_value = $urandom_range(1) ? FRACTION_ONE : 7'($urandom_range(99));
      r.code_number    = known_codes[$urandom_range(known_codes.size() - 1)];
      if (pick < 70) begin
         r.cmd = CMD_SET;
      end else if (pick < 78) begin
         r.cmd         = CMD_SET;
         r.code_number = 8'($urandom_range(255));
      end else if (pick < 88) begin
         r.cmd = CMD_CLEAR_ONE;
         if ($urandom_range(1)) r.code_number = 8'($urandom_range(255));
      end else if (pick < 93) begin
         r.cmd = CMD_CLEAR_ALL;
      end else begin
         r.cmd = CMD_NEW_BLOCK;
      end
      return r;
   endfunction

   // program-like blocks: new block, then a few words
   task automatic push_random(input int count);
      int pushed;
      int words;
      pushed = 0;
      while (pushed < count) begin
         pending_cmds.push_back(make_cmd(CMD_NEW_BLOCK, 8'($urandom_range(255)),
                                         1'($urandom_range(1)), 7'($urandom_range(99))));
         words = $urandom_range(1, 4);
         for (int i = 0; i < words; i++) pending_cmds.push_back(random_cmd());
         pushed += words + 1;
      end
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_if.valid || expected_state.size() != 0)
         @(negedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic [127:0] got,
                                  input logic [127:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_type r;
            r = pending_cmds.pop_front();
            req_if.valid          <= 1'b1;
            req_if.cmd            <= r.cmd;
            req_if.code_number    <= r.code_number;
            req_if.has_fraction   <= r.has_fraction;
            req_if.fraction_value <= r.fraction_value;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result receiver, with a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_ack_count != hold_req_count) begin
         hold_ack_count = hold_req_count;
         hold_left      = HOLD_CYCLES;
         rsp_if.ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // input monitor: model update per accepted command
   always @(posedge clock) begin
      if (reset) begin
         model_flags  = FLAG_RESET;
         model_offset = OFFSET_RESET;
         model_stop   = 1'b0;
         model_abs    = 1'b0;
         model_drill  = 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         expected_state.push_back(predict_state(make_cmd(req_if.cmd, req_if.code_number,
                                  req_if.has_fraction, req_if.fraction_value)));
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_state.size() == 0) begin
            $display("unexpected result transfer at %0t", $realtime);
            error_count++;
         end else begin
            rsp_type e;
            e = expected_state.pop_front();
            if (rsp_if.code_known !== e.code_known)
               report_mismatch("code_known", 128'(rsp_if.code_known),
                               128'(e.code_known));
            if (rsp_if.reported_code !== e.reported_code)
               report_mismatch("reported_code", 128'(rsp_if.reported_code),
                               128'(e.reported_code));
            if (rsp_if.active_low !== e.active_low)
               report_mismatch("active_low", 128'(rsp_if.active_low),
                               128'(e.active_low));
            if (rsp_if.active_high !== e.active_high)
               report_mismatch("active_high", 128'(rsp_if.active_high),
                               128'(e.active_high));
            if (rsp_if.work_offset !== e.work_offset)
               report_mismatch("work_offset", 128'(rsp_if.work_offset),
                               128'(e.work_offset));
            if (rsp_if.exact_stop !== e.exact_stop)
               report_mismatch("exact_stop", 128'(rsp_if.exact_stop),
                               128'(e.exact_stop));
            if (rsp_if.abs_arc_centres !== e.abs_arc_centres)
               report_mismatch("abs_arc_centres", 128'(rsp_if.abs_arc_centres),
                               128'(e.abs_arc_centres));
            if (rsp_if.drill_plane_init !== e.drill_plane_init)
               report_mismatch("drill_plane_init", 128'(rsp_if.drill_plane_init),
                               128'(e.drill_plane_init));
         end
      end
   end

   // watchdog: cycles with work outstanding but no transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (pending_cmds.size() == 0 && !req_if.valid && expected_state.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired at %0t", $realtime);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset                 = 1'b1;
      req_if.valid          = 1'b0;
      req_if.cmd            = CMD_NEW_BLOCK;
      req_if.code_number    = 8'd0;
      req_if.has_fraction   = 1'b0;
      req_if.fraction_value = 7'd0;
      rsp_if.ready          = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed
      pending_cmds.push_back(make_cmd(CMD_SET, G00, 1'b1, 7'd99));
      pending_cmds.push_back(make_cmd(CMD_SET, G02, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_SET, G102, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_SET, G01, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_SET, G61, 1'b1, FRACTION_ONE));
      pending_cmds.push_back(make_cmd(CMD_SET, G61, 1'b1, 7'd2));
      pending_cmds.push_back(make_cmd(CMD_SET, G64, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_SET, G81, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_SET, G83, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_NEW_BLOCK, 8'd255, 1'b1, 7'd127));
      pending_cmds.push_back(make_cmd(CMD_SET, G80, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_SET, G83, 1'b1, 7'd64));
      pending_cmds.push_back(make_cmd(CMD_SET, G90, 1'b1, FRACTION_ONE));
      pending_cmds.push_back(make_cmd(CMD_SET, G91, 1'b1, 7'd5));
      pending_cmds.push_back(make_cmd(CMD_SET, G91, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_SET, G91, 1'b1, FRACTION_ONE));
      pending_cmds.push_back(make_cmd(CMD_SET, G28, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_SET, G53, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_SET, G59, 1'b1, 7'd28));
      pending_cmds.push_back(make_cmd(CMD_SET, 8'd255, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_SET, 8'd127, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_CLEAR_ONE, 8'd255, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_CLEAR_ONE, 8'd127, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_CLEAR_ONE, G00, 1'b0, 7'd0));
      pending_cmds.push_back(make_cmd(CMD_CLEAR_ALL, G00, 1'b0, 7'd0));
      wait_drained();

      // no idling, with a long output hold while the input keeps coming
      push_random(PHASE_ITEMS / 2);
      hold_req_count++;
      wait_drained();
      push_random(PHASE_ITEMS / 2);
      wait_drained();

      send_idle_pct = 56;
      push_random(PHASE_ITEMS);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 56;
      push_random(PHASE_ITEMS);
      wait_drained();

      send_idle_pct  = 33;
      recv_stall_pct = 33;
      push_random(PHASE_ITEMS);
      wait_drained();

      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== gcode_modal_state_tracker.f =====
+incdir+design
design/gmst_pkg.sv
design/gmst_channels.sv
design/gmst_in_reg.sv
design/gmst_update.sv
design/gmst_out_reg.sv
design/gcode_modal_state_tracker.sv
design/gmst_checker.sv
tb/testbench.sv
